// ===== src/psrr_pkg.sv =====
// psrr_pkg: shared types and codes for the round robin / priority process scheduler
// used by process_scheduler_rr_priority and its checker; no dependencies
`default_nettype none
package psrr_pkg;
    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;
    // status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_RAN       = 3'd2;
    localparam logic [2:0] ST_FINISHED  = 3'd3;
    localparam logic [2:0] ST_PREEMPTED = 3'd4;
    localparam logic [2:0] ST_IDLE      = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;
    // configuration register indexes
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_DECAY = 1'b1;
    localparam logic [3:0] DECAY_RESET = 4'd3;
    localparam logic signed [8:0] PRIO_FLOOR = -9'sd128;

    // one table entry
    typedef struct packed {
        logic [7:0] prio;
        logic [3:0] used;
        logic [3:0] work;
        logic [3:0] link;
    } entry_t;
endpackage
`default_nettype wire

// ===== src/process_scheduler_rr_priority.sv =====
// process_scheduler_rr_priority: top level, process table in one synchronous memory
// depends on psrr_pkg
`default_nettype none
// A word occupies the block for the shortest time on a clear, refused add, idle tick
// or unknown command, and for the longest on a priority-mode tick that dispatches the
// head, preempts the runner and walks the rest of the queue to re-insert it. The process
// table sits in a single one-port-write, one-port-read memory with a registered read,
// and every linked-list step (pop, append, sorted insertion walk) costs one read and its
// wait; the sorted walk sets the upper bound. One word is worked at a time; the result
// sits in an output register and no new word is taken until it is accepted, though a
// word can be taken in the cycle the result leaves. No clearing pass: entries are always
// written before they are read.
module process_scheduler_rr_priority
    import psrr_pkg::*;
#(
    parameter int MAX_PROCS = 8
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] cmd,
    input  wire logic [5:0] new_priority,
    input  wire logic [3:0] new_work,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      status,
    output logic [3:0]      proc_id,
    output logic [3:0]      next_run,
    output logic [3:0]      work_left,
    output logic [3:0]      used_time,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [3:0] cfg_data
);
    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_RDRUN  = 15'b000000000000010, // load runner entry read while idle
        S_TICK   = 15'b000000000000100, // update runner
        S_POPRD  = 15'b000000000001000, // read head for pop
        S_POP    = 15'b000000000010000,
        S_HDRD   = 15'b000000000100000, // read head prio for preempt test
        S_HDCMP  = 15'b000000001000000,
        S_ENQ    = 15'b000000010000000, // start enqueue of enq_id
        S_TLRD   = 15'b000000100000000, // read tail for append
        S_TLWR   = 15'b000001000000000,
        S_WKRD   = 15'b000010000000000, // walk sorted list
        S_WKCMP  = 15'b000100000000000,
        S_PVRD   = 15'b001000000000000, // read prev for link
        S_PVWR   = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } state_t;

    localparam int IW = 4;

    state_t state_reg, state_next;
    logic [IW-1:0] running_reg, head_reg, tail_reg, count_reg;
    logic          mode_reg;
    logic [3:0]    decay_reg;
    logic [2:0]    st_reg;
    logic [3:0]    pid_reg, wl_reg, ut_reg;
    logic          out_valid_reg;
    // runner entry held locally while worked on
    entry_t        run_reg;
    logic [IW-1:0] enq_id_reg, prev_reg, cur_reg, walk_n_reg;
    logic [7:0]    enq_prio_reg;
    logic          after_pop_reg; // 0 dispatch before tick, 1 hand-over after tick

    // table memory
    entry_t        mem [1:MAX_PROCS];
    logic [IW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    entry_t        wr_data, rd_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign in_ready  = (state_reg == S_IDLE) && !(out_valid_reg && !out_ready);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = st_reg;
    assign proc_id   = pid_reg;
    assign next_run  = running_reg;
    assign work_left = wl_reg;
    assign used_time = ut_reg;

    // runner priority after decay
    logic signed [8:0] dec_prio;
    logic [7:0]        dec_prio8;
    always_comb
    begin
        dec_prio  = $signed({run_reg.prio[7], run_reg.prio}) - $signed({5'd0, decay_reg});
        dec_prio8 = (dec_prio < PRIO_FLOOR) ? 8'h80 : dec_prio[7:0];
    end

    // runner entry after this tick
    entry_t tick_ent;
    always_comb
    begin
        tick_ent      = run_reg;
        tick_ent.used = run_reg.used + 4'd1;
        tick_ent.work = (run_reg.work != 4'd0) ? run_reg.work - 4'd1 : 4'd0;
        if (mode_reg)
        begin
            tick_ent.prio = dec_prio8;
        end
    end

    // control and datapath
    logic [IW-1:0] running_next, head_next, tail_next, count_next;
    always_comb
    begin
        state_next   = state_reg;
        running_next = running_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        rd_addr      = running_reg;
        wr_addr      = running_reg;
        wr_en        = 1'b0;
        wr_data      = run_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // runner entry is read while waiting for a word
                rd_addr = running_reg;
                if (in_valid && in_ready)
                begin
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            running_next = '0;
                            head_next    = '0;
                            tail_next    = '0;
                            count_next   = '0;
                            state_next   = S_DONE;
                        end
                        CMD_ADD:
                        begin
                            state_next = (count_reg >= IW'(MAX_PROCS)) ? S_DONE : S_ENQ;
                            if (count_reg < IW'(MAX_PROCS))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            state_next = (running_reg != '0) ? S_RDRUN
                                       : (head_reg != '0) ? S_POPRD : S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_POPRD:
            begin
                rd_addr    = head_reg;
                state_next = S_POP;
            end
            S_POP:
            begin
                // head leaves the queue and becomes runner
                running_next = head_reg;
                head_next    = rd_data.link;
                if (rd_data.link == '0)
                begin
                    tail_next = '0;
                end
                if (!after_pop_reg)
                begin
                    state_next = S_TICK;
                end
                else
                begin
                    // a preempted runner goes back into the queue
                    state_next = (st_reg == ST_PREEMPTED) ? S_ENQ : S_DONE;
                end
            end
            S_RDRUN:
            begin
                rd_addr    = running_reg;
                state_next = S_TICK;
            end
            S_TICK:
            begin
                wr_en   = 1'b1;
                wr_addr = running_reg;
                wr_data = tick_ent;
                if (tick_ent.work == 4'd0)
                begin
                    wr_data.link = '0;
                    running_next = '0;
                    state_next   = (head_reg != '0) ? S_POPRD : S_DONE;
                end
                else if (head_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (mode_reg)
                begin
                    state_next = S_HDRD;
                end
                else if ({4'd0, tick_ent.used} == tick_ent.prio)
                begin
                    wr_data.used = 4'd0;
                    state_next   = S_POPRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_HDRD:
            begin
                rd_addr    = head_reg;
                state_next = S_HDCMP;
            end
            S_HDCMP:
            begin
                state_next = ($signed(run_reg.prio) < $signed(rd_data.prio)) ? S_POPRD : S_DONE;
            end
            S_ENQ:
            begin
                if (!mode_reg)
                begin
                    if (head_reg == '0)
                    begin
                        head_next  = enq_id_reg;
                        tail_next  = enq_id_reg;
                        wr_en      = 1'b1;
                        wr_addr    = enq_id_reg;
                        wr_data    = run_reg;
                        wr_data.link = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_TLRD;
                    end
                end
                else
                begin
                    state_next = S_WKRD;
                end
            end
            S_TLRD:
            begin
                rd_addr    = tail_reg;
                wr_en      = 1'b1;
                wr_addr    = enq_id_reg;
                wr_data    = run_reg;
                wr_data.link = '0;
                state_next = S_TLWR;
            end
            S_TLWR:
            begin
                wr_en        = 1'b1;
                wr_addr      = tail_reg;
                wr_data      = rd_data;
                wr_data.link = enq_id_reg;
                tail_next    = enq_id_reg;
                state_next   = S_DONE;
            end
            S_WKRD:
            begin
                rd_addr = cur_reg;
                if (cur_reg == '0 || walk_n_reg >= IW'(MAX_PROCS))
                begin
                    // insert before cur
                    wr_en        = 1'b1;
                    wr_addr      = enq_id_reg;
                    wr_data      = run_reg;
                    wr_data.link = cur_reg;
                    if (cur_reg == '0)
                    begin
                        tail_next = enq_id_reg;
                    end
                    if (prev_reg == '0)
                    begin
                        head_next  = enq_id_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PVRD;
                    end
                end
                else
                begin
                    state_next = S_WKCMP;
                end
            end
            S_WKCMP:
            begin
                state_next = S_WKRD;
                if (!($signed(rd_data.prio) > $signed(enq_prio_reg)))
                begin
                    wr_en        = 1'b1;
                    wr_addr      = enq_id_reg;
                    wr_data      = run_reg;
                    wr_data.link = cur_reg;
                    state_next   = (prev_reg == '0) ? S_DONE : S_PVRD;
                    if (prev_reg == '0)
                    begin
                        head_next = enq_id_reg;
                    end
                end
            end
            S_PVRD:
            begin
                rd_addr    = prev_reg;
                state_next = S_PVWR;
            end
            S_PVWR:
            begin
                wr_en        = 1'b1;
                wr_addr      = prev_reg;
                wr_data      = rd_data;
                wr_data.link = enq_id_reg;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            running_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            mode_reg      <= 1'b0;
            decay_reg     <= DECAY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MODE)
                begin
                    mode_reg <= cfg_data[0];
                end
                else
                begin
                    decay_reg <= cfg_data;
                end
            end
            if (state_reg == S_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    after_pop_reg <= 1'b0;
                    wl_reg        <= '0;
                    ut_reg        <= '0;
                    prev_reg      <= '0;
                    cur_reg       <= head_reg;
                    walk_n_reg    <= '0;
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            st_reg  <= ST_CLEARED;
                            pid_reg <= '0;
                        end
                        CMD_ADD:
                        begin
                            if (count_reg >= IW'(MAX_PROCS))
                            begin
                                st_reg  <= ST_FULL;
                                pid_reg <= '0;
                            end
                            else
                            begin
                                st_reg       <= ST_ADDED;
                                pid_reg      <= count_reg + 1'b1;
                                enq_id_reg   <= count_reg + 1'b1;
                                enq_prio_reg <= {2'b00, new_priority};
                                run_reg      <= '{prio: {2'b00, new_priority}, used: 4'd0,
                                                  work: new_work, link: 4'd0};
                            end
                        end
                        default:
                        begin
                            st_reg  <= ST_IDLE;
                            pid_reg <= '0;
                        end
                    endcase
                end
            end
            S_POPRD:
            begin
                // preempt: remember the old runner for the re-queue after the pop
                if (after_pop_reg && st_reg == ST_PREEMPTED)
                begin
                    enq_id_reg   <= pid_reg;
                    enq_prio_reg <= run_reg.prio;
                end
            end
            S_POP:
            begin
                if (!after_pop_reg)
                begin
                    run_reg <= rd_data;
                    pid_reg <= head_reg;
                end
                // sorted walk restarts at the new head
                prev_reg   <= '0;
                cur_reg    <= rd_data.link;
                walk_n_reg <= '0;
            end
            S_RDRUN:
            begin
                run_reg <= rd_data;
                pid_reg <= running_reg;
            end
            S_TICK:
            begin
                wl_reg        <= tick_ent.work;
                run_reg       <= wr_data;
                after_pop_reg <= 1'b1;
                if (tick_ent.work == 4'd0)
                begin
                    st_reg <= ST_FINISHED;
                    ut_reg <= tick_ent.used;
                end
                else if (!mode_reg && head_reg != '0 && {4'd0, tick_ent.used} == tick_ent.prio)
                begin
                    // rotate: old runner goes back in after the pop
                    st_reg <= ST_PREEMPTED;
                    ut_reg <= 4'd0;
                end
                else
                begin
                    st_reg <= ST_RAN;
                    ut_reg <= tick_ent.used;
                end
            end
            S_HDCMP:
            begin
                if ($signed(run_reg.prio) < $signed(rd_data.prio))
                begin
                    st_reg <= ST_PREEMPTED;
                end
            end
            S_WKCMP:
            begin
                if ($signed(rd_data.prio) > $signed(enq_prio_reg))
                begin
                    prev_reg   <= cur_reg;
                    cur_reg    <= rd_data.link;
                    walk_n_reg <= walk_n_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/psrr_checker.sv =====
// psrr_checker: port-level assertions for process_scheduler_rr_priority
// depends on psrr_pkg; bound to the top level below
`default_nettype none
module psrr_checker
    import psrr_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] status,
    input wire logic [3:0] proc_id,
    input wire logic [3:0] next_run
);
    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(proc_id))
        else $error("result changed while stalled");
    // cleared answers carry no id
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_CLEARED) |-> proc_id == 4'd0 && next_run == 4'd0)
        else $error("clear reported an id");
    // added words carry an id
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ADDED) |-> proc_id != 4'd0)
        else $error("add without id");
    // no status code beyond cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_CLEARED)
        else $error("bad status");
    // no word taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !(out_valid && !out_ready))
        else $error("word taken over a waiting result");
endmodule

bind process_scheduler_rr_priority psrr_checker u_psrr_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .proc_id(proc_id), .next_run(next_run)
);
`default_nettype wire

// ===== verif/process_scheduler_rr_priority_tb.sv =====
// process_scheduler_rr_priority_tb: self-checking bench for the process scheduler
// depends on psrr_pkg and process_scheduler_rr_priority
`default_nettype none
module process_scheduler_rr_priority_tb;
    import psrr_pkg::*;

    localparam int NPROC = 8;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] proc_id;
        logic [3:0] next_run;
        logic [3:0] work_left;
        logic [3:0] used_time;
    } sched_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = CMD_CLEAR;
    logic [5:0] new_priority = 6'd1;
    logic [3:0] new_work = 4'd1;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [3:0] proc_id;
    logic [3:0] next_run;
    logic [3:0] work_left;
    logic [3:0] used_time;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = REG_MODE;
    logic [3:0] cfg_data = 4'd0;

    // shadow of the process table
    logic [7:0] tbl_prio [0:NPROC];
    logic [3:0] tbl_used [0:NPROC];
    logic [3:0] tbl_work [0:NPROC];
    logic [3:0] tbl_link [0:NPROC];
    logic [3:0] cur_run, q_head, q_tail, n_loaded;
    logic       mode_prio;
    logic [3:0] decay;

    sched_word_t expected_words[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    process_scheduler_rr_priority #(.MAX_PROCS(NPROC)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .new_priority(new_priority), .new_work(new_work),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .proc_id(proc_id), .next_run(next_run),
        .work_left(work_left), .used_time(used_time),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int prio_val(input logic [3:0] id);
        return int'($signed(tbl_prio[id]));
    endfunction

    function automatic logic [3:0] pop_queue();
        logic [3:0] id;
        id = q_head;
        if (id != 0)
        begin
            q_head = tbl_link[id];
            if (q_head == 0)
                q_tail = '0;
            tbl_link[id] = '0;
        end
        return id;
    endfunction

    function automatic void queue_process(input logic [3:0] id);
        logic [3:0] prev, cur;
        int n;
        if (!mode_prio)
        begin
            tbl_link[id] = '0;
            if (q_head == 0)
                q_head = id;
            else
                tbl_link[q_tail] = id;
            q_tail = id;
        end
        else
        begin
            prev = '0;
            cur = q_head;
            n = 0;
            while (cur != 0 && n < NPROC && prio_val(cur) > prio_val(id))
            begin
                prev = cur;
                cur = tbl_link[cur];
                n++;
            end
            tbl_link[id] = cur;
            if (prev == 0)
                q_head = id;
            else
                tbl_link[prev] = id;
            if (cur == 0)
                q_tail = id;
        end
    endfunction

    // compute the scheduler's answer to one word and update the shadow table
    function automatic sched_word_t schedule_word(input logic [1:0] c, input logic [5:0] np,
                                                   input logic [3:0] nw);
        sched_word_t w;
        logic [3:0] r, nxt;
        int p;
        logic swap;
        w = '0;
        w.status = ST_IDLE;
        if (c == CMD_CLEAR)
        begin
            cur_run = '0; q_head = '0; q_tail = '0; n_loaded = '0;
            w.status = ST_CLEARED;
        end
        else if (c == CMD_ADD)
        begin
            if (n_loaded >= NPROC)
                w.status = ST_FULL;
            else
            begin
                n_loaded = n_loaded + 4'd1;
                tbl_prio[n_loaded] = {2'b00, np};
                tbl_used[n_loaded] = '0;
                tbl_work[n_loaded] = nw;
                queue_process(n_loaded);
                w.status = ST_ADDED;
                w.proc_id = n_loaded;
            end
        end
        else if (c == CMD_TICK)
        begin
            if (cur_run == 0)
                cur_run = pop_queue();
            if (cur_run != 0)
            begin
                r = cur_run;
                w.proc_id = r;
                tbl_used[r] = tbl_used[r] + 4'd1;
                if (tbl_work[r] != 0)
                    tbl_work[r] = tbl_work[r] - 4'd1;
                if (mode_prio)
                begin
                    p = prio_val(r) - int'(decay);
                    if (p < -128)
                        p = -128;
                    tbl_prio[r] = p[7:0];
                end
                w.status = ST_RAN;
                if (tbl_work[r] == 0)
                begin
                    tbl_link[r] = '0;
                    cur_run = pop_queue();
                    w.status = ST_FINISHED;
                end
                else if (q_head != 0)
                begin
                    if (mode_prio)
                        swap = prio_val(r) < prio_val(q_head);
                    else
                        swap = int'(tbl_used[r]) == prio_val(r);
                    if (swap)
                    begin
                        nxt = pop_queue();
                        if (!mode_prio)
                            tbl_used[r] = '0;
                        queue_process(r);
                        cur_run = nxt;
                        w.status = ST_PREEMPTED;
                    end
                end
                w.work_left = tbl_work[r];
                w.used_time = tbl_used[r];
            end
        end
        w.next_run = cur_run;
        return w;
    endfunction

    // send one word, predicting its result on acceptance
    task automatic send_word(input logic [1:0] c, input logic [5:0] np, input logic [3:0] nw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= c;
        new_priority <= np;
        new_work <= nw;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_words.push_back(schedule_word(c, np, nw));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_words.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        wait_drained();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MODE)
            mode_prio = val[0];
        else
            decay = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_proc(input logic [5:0] np, input logic [3:0] nw);
        send_word(CMD_ADD, np, nw);
    endtask

    task automatic tick();
        send_word(CMD_TICK, 6'($urandom), 4'($urandom));
    endtask

    // receiver stall and result compare
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        sched_word_t got, exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, proc_id, next_run, work_left, used_time};
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (got !== exp_w)
                begin
                    $display("%0t: mismatch expected st=%0d id=%0d nx=%0d wl=%0d ut=%0d", $time,
                             exp_w.status, exp_w.proc_id, exp_w.next_run, exp_w.work_left,
                             exp_w.used_time);
                    $display("%0t:          actual   st=%0d id=%0d nx=%0d wl=%0d ut=%0d", $time,
                             got.status, got.proc_id, got.next_run, got.work_left,
                             got.used_time);
                    errors++;
                end
            end
        end
    end

    // directed: edges of fields, full table, idle, unknown command
    task automatic test_directed_rr();
        send_word(CMD_TICK, 6'd0, 4'd0);
        send_word(CMD_NONE, 6'd63, 4'd15);
        add_proc(6'd63, 4'd15);
        add_proc(6'd1, 4'd1);
        add_proc(6'd2, 4'd3);
        for (int i = 0; i < 6; i++)
            add_proc(6'($urandom_range(1, 63)), 4'($urandom_range(1, 15)));
        repeat (12) tick();
        send_word(CMD_NONE, 6'd0, 4'd0);
        send_word(CMD_CLEAR, 6'd0, 4'd0);
        add_proc(6'd1, 4'd2);
        repeat (4) tick();
    endtask

    // directed priority mode with heavy decay to reach the floor
    task automatic test_directed_prio();
        write_reg(REG_MODE, 4'd1);
        write_reg(REG_DECAY, 4'd15);
        send_word(CMD_CLEAR, 6'd0, 4'd0);
        add_proc(6'd1, 4'd15);
        add_proc(6'd1, 4'd15);
        add_proc(6'd63, 4'd2);
        repeat (20) tick();
    endtask

    // random sessions: clear, adds, ticks, now and then an unknown command
    task automatic test_random(input int words);
        int sent;
        sent = 0;
        while (sent < words)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_word(CMD_CLEAR, 6'($urandom), 4'($urandom));
                sent++;
            end
            else if ($urandom_range(9) < 3)
            begin
                if ($urandom_range(19) == 0)
                    add_proc(6'($urandom), 4'($urandom));
                else
                    add_proc(6'($urandom_range(1, 63)), 4'($urandom_range(1, 15)));
                sent++;
            end
            else
            begin
                if ($urandom_range(49) == 0)
                    send_word(CMD_NONE, 6'($urandom), 4'($urandom));
                else
                    tick();
                sent++;
            end
        end
    endtask

    initial
    begin
        cur_run = '0; q_head = '0; q_tail = '0; n_loaded = '0;
        mode_prio = 1'b0;
        decay = DECAY_RESET;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_rr();
        test_directed_prio();
        // sender pauses until the pipe is empty
        wait_drained();

        write_reg(REG_MODE, 4'd0);
        test_random(180);
        write_reg(REG_MODE, 4'd1);
        write_reg(REG_DECAY, 4'd0);
        send_idle_pct = 67;
        test_random(170);
        write_reg(REG_DECAY, 4'd3);
        send_idle_pct = 0;
        recv_stall_pct = 67;
        test_random(170);
        write_reg(REG_MODE, 4'd0);
        write_reg(REG_DECAY, 4'd7);
        send_idle_pct = 31;
        recv_stall_pct = 31;
        test_random(90);
        write_reg(REG_MODE, 4'd1);
        test_random(90);
        send_idle_pct = 0;
        recv_stall_pct = 0;

        wait_drained();
        if (errors == 0 && expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== process_scheduler_rr_priority.f =====
src/psrr_pkg.sv
src/process_scheduler_rr_priority.sv
src/psrr_checker.sv
verif/process_scheduler_rr_priority_tb.sv
